[design/lorm_pkg.sv]
// ----------------------------------------------------------------------------
// lorm_pkg
// Shared types and codes of the LRU object residency manager.
// ----------------------------------------------------------------------------
package lorm_pkg;

  localparam int ID_W    = 12;
  localparam int OP_W    = 3;
  localparam int KIND_W  = 3;
  localparam int COUNT_W = 7;
  localparam int LOC_W   = 3;
  localparam int FLAG_W  = 2;
  localparam int CAP_W   = 6;
  localparam int ENTRY_W = LOC_W + FLAG_W;

  localparam logic [OP_W-1:0] OP_ACCESS  = 3'd0;
  localparam logic [OP_W-1:0] OP_UNLOAD  = 3'd1;
  localparam logic [OP_W-1:0] OP_TRIM    = 3'd2;
  localparam logic [OP_W-1:0] OP_MODIFY  = 3'd3;
  localparam logic [OP_W-1:0] OP_GARBAGE = 3'd4;

  localparam logic [KIND_W-1:0] KIND_ACK        = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FETCH_DB   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FETCH_LOG  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_WRITE_BACK = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAN_DROP = 3'd4;
  localparam logic [KIND_W-1:0] KIND_GARB_DROP  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_IGNORED    = 3'd6;
  localparam logic [KIND_W-1:0] KIND_OVERFLOW   = 3'd7;

  localparam logic [LOC_W-1:0] LOC_DB       = 3'd0;
  localparam logic [LOC_W-1:0] LOC_LOG      = 3'd1;
  localparam logic [LOC_W-1:0] LOC_FROM_DB  = 3'd2;
  localparam logic [LOC_W-1:0] LOC_FROM_LOG = 3'd3;
  localparam logic [LOC_W-1:0] LOC_DIRTY    = 3'd4;

  localparam int FLAG_RES  = 0;
  localparam int FLAG_GARB = 1;

  localparam logic [COUNT_W-1:0] MAX_OUT   = 7'd64;
  localparam logic [CAP_W-1:0]   CAP_RESET = 6'd32;
  localparam logic               REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] object_id;
  } req_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [ID_W-1:0]    object_id_out;
    logic [COUNT_W-1:0] resident_count;
    logic               last;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_OBJ_RD, ST_DECIDE, ST_SCAN_RD, ST_SCAN_WR,
    ST_TRIM_CHK, ST_TRIM_TAKE, ST_TRIM_OBJ, ST_TRIM_DEC, ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    OBJ_NONE, OBJ_FETCH, OBJ_UNLOAD, OBJ_MODIFY, OBJ_GARBAGE, OBJ_EVICT
  } obj_op_t;

  typedef struct packed {
    logic              clr_step;
    logic              accept;
    obj_op_t           obj_op;
    logic              set_res;
    logic [KIND_W-1:0] res_kind;
    logic              res_last;
    logic              res_zero;
    logic              scan_start;
    logic              scan_remove;
    logic              scan_grow;
    logic              scan_step;
    logic              scan_finish;
    logic              tail_rd;
    logic              evict_take;
    logic              load_out;
  } cmd_t;

  typedef struct packed {
    logic              clr_done;
    logic [OP_W-1:0]   op;
    logic              id_bad;
    logic              res;
    logic              garb;
    logic              full;
    logic              over_cap;
    logic              scan_end;
    logic              match;
    logic              scan_remove;
    logic              n_limit;
    logic [KIND_W-1:0] fetch_kind;
    logic [KIND_W-1:0] evict_kind;
    logic              res_last;
    logic              out_free;
  } status_t;

endpackage

[design/lorm_ram.sv]
// ----------------------------------------------------------------------------
// lorm_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module lorm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/lorm_ctrl.sv]
// ----------------------------------------------------------------------------
// lorm_ctrl
// Controller state machine that sequences lookups, list scans and evictions.
// ----------------------------------------------------------------------------
module lorm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  lorm_pkg::status_t st,
  output lorm_pkg::cmd_t    cmd
);
  import lorm_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_OBJ_RD;
        end
      end
      ST_OBJ_RD: begin
        if (st.op == OP_TRIM) begin
          state_next = ST_TRIM_CHK;
        end else if (st.id_bad) begin
          cmd.set_res  = 1'b1;
          cmd.res_kind = KIND_IGNORED;
          cmd.res_last = 1'b1;
          state_next   = ST_EMIT;
        end else begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.set_res  = 1'b1;
        cmd.res_last = 1'b1;
        cmd.res_kind = KIND_ACK;
        state_next   = ST_EMIT;
        priority if (st.op == OP_ACCESS) begin
          if (st.res) begin
            cmd.scan_start = 1'b1;
            state_next     = ST_SCAN_RD;
          end else if (st.garb) begin
            cmd.res_kind = KIND_IGNORED;
          end else if (st.full) begin
            cmd.res_kind = KIND_OVERFLOW;
          end else begin
            cmd.obj_op     = OBJ_FETCH;
            cmd.res_kind   = st.fetch_kind;
            cmd.scan_start = 1'b1;
            cmd.scan_grow  = 1'b1;
            state_next     = ST_SCAN_RD;
          end
        end else if (st.op == OP_UNLOAD) begin
          cmd.obj_op = OBJ_UNLOAD;
          if (st.res) begin
            cmd.scan_start  = 1'b1;
            cmd.scan_remove = 1'b1;
            state_next      = ST_SCAN_RD;
          end
        end else if (st.op == OP_MODIFY) begin
          if (st.res) begin
            cmd.obj_op = OBJ_MODIFY;
          end else begin
            cmd.res_kind = KIND_IGNORED;
          end
        end else if (st.op == OP_GARBAGE) begin
          cmd.obj_op = OBJ_GARBAGE;
        end else begin
          cmd.res_kind = KIND_IGNORED;
        end
      end
      ST_SCAN_RD: begin
        if (st.scan_end) begin
          cmd.scan_finish = 1'b1;
          state_next      = ST_EMIT;
        end else begin
          state_next = ST_SCAN_WR;
        end
      end
      ST_SCAN_WR: begin
        cmd.scan_step = 1'b1;
        if (!st.scan_remove && st.match) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_TRIM_CHK: begin
        if (st.over_cap) begin
          cmd.tail_rd = 1'b1;
          state_next  = ST_TRIM_TAKE;
        end else begin
          cmd.set_res  = 1'b1;
          cmd.res_kind = KIND_ACK;
          cmd.res_last = 1'b1;
          cmd.res_zero = 1'b1;
          state_next   = ST_EMIT;
        end
      end
      ST_TRIM_TAKE: begin
        cmd.evict_take = 1'b1;
        state_next     = ST_TRIM_OBJ;
      end
      ST_TRIM_OBJ: begin
        state_next = ST_TRIM_DEC;
      end
      ST_TRIM_DEC: begin
        cmd.obj_op   = OBJ_EVICT;
        cmd.set_res  = 1'b1;
        cmd.res_kind = st.evict_kind;
        cmd.res_last = !st.over_cap || st.n_limit;
        state_next   = ST_EMIT;
      end
      ST_EMIT: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = st.res_last ? ST_IDLE : ST_TRIM_CHK;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[design/lorm_dp.sv]
// ----------------------------------------------------------------------------
// lorm_dp
// Datapath: recency list and object table memories, counters and result word.
// ----------------------------------------------------------------------------
module lorm_dp #(
  parameter int RESIDENT_SLOTS = 64,
  parameter int OBJECT_COUNT   = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  lorm_pkg::req_t                 req,
  input  lorm_pkg::cmd_t                 cmd,
  input  logic [lorm_pkg::CAP_W-1:0]     capacity,
  output lorm_pkg::status_t              st,
  output lorm_pkg::rsp_t                 rsp,
  output logic                           rsp_valid,
  input  logic                           rsp_stall
);
  import lorm_pkg::*;

  localparam int LIST_AW = $clog2(RESIDENT_SLOTS);
  localparam int CNT_W   = $clog2(RESIDENT_SLOTS + 1);
  localparam int OBJ_AW  = $clog2(OBJECT_COUNT);

  logic [OP_W-1:0]    op_r;
  logic [ID_W-1:0]    cur_id;
  logic [CNT_W-1:0]   total;
  logic [CNT_W-1:0]   idx;
  logic [ID_W-1:0]    carry;
  logic               found;
  logic               scan_remove_r;
  logic               grow_r;
  logic [COUNT_W-1:0] n;
  logic [KIND_W-1:0]  res_kind;
  logic               res_last;
  logic               res_zero;
  logic [OBJ_AW-1:0]  clr_addr;

  logic [CNT_W-1:0]         total_m1;
  logic [CNT_W-1:0]         idx_m1;
  logic [LIST_AW-1:0]       list_raddr;
  logic [LIST_AW-1:0]       list_waddr;
  logic                     list_we;
  logic [ID_W-1:0]          list_wdata;
  logic [ID_W-1:0]          list_rdata;
  logic [OBJ_AW+ID_W-1:0]   id_ext;
  logic [OBJ_AW-1:0]        obj_addr;
  logic                     obj_we;
  logic [OBJ_AW-1:0]        obj_waddr;
  logic [ENTRY_W-1:0]       obj_wdata;
  logic [ENTRY_W-1:0]       obj_rdata;
  logic [LOC_W-1:0]         loc;
  logic [FLAG_W-1:0]        flags;
  logic [LOC_W-1:0]         loc_new;
  logic [FLAG_W-1:0]        flags_new;
  logic [COUNT_W+CNT_W-1:0] total_ext;

  assign total_m1   = total - 1'b1;
  assign idx_m1     = idx - 1'b1;
  assign list_raddr = cmd.tail_rd ? total_m1[LIST_AW-1:0] : idx[LIST_AW-1:0];
  assign id_ext     = {{OBJ_AW{1'b0}}, cur_id};
  assign obj_addr   = id_ext[OBJ_AW-1:0];
  assign loc        = obj_rdata[ENTRY_W-1:FLAG_W];
  assign flags      = obj_rdata[FLAG_W-1:0];
  assign total_ext  = {{COUNT_W{1'b0}}, total};

  always_comb begin
    list_we    = 1'b0;
    list_waddr = idx[LIST_AW-1:0];
    list_wdata = carry;
    if (cmd.scan_step) begin
      if (scan_remove_r) begin
        list_we    = found;
        list_waddr = idx_m1[LIST_AW-1:0];
        list_wdata = list_rdata;
      end else begin
        list_we = 1'b1;
      end
    end else if (cmd.scan_finish) begin
      list_we = !scan_remove_r && grow_r;
    end
  end

  always_comb begin
    loc_new   = loc;
    flags_new = flags;
    unique case (cmd.obj_op)
      OBJ_FETCH: begin
        if (loc == LOC_LOG) begin
          loc_new = LOC_FROM_LOG;
        end else if (loc == LOC_DB) begin
          loc_new = LOC_FROM_DB;
        end
        flags_new[FLAG_RES] = 1'b1;
      end
      OBJ_UNLOAD: begin
        loc_new             = LOC_DIRTY;
        flags_new[FLAG_RES] = 1'b0;
      end
      OBJ_MODIFY: begin
        loc_new = LOC_DIRTY;
      end
      OBJ_GARBAGE: begin
        flags_new[FLAG_GARB] = 1'b1;
      end
      OBJ_EVICT: begin
        priority if (flags[FLAG_GARB]) begin
          loc_new = LOC_DIRTY;
        end else if (loc == LOC_DIRTY) begin
          loc_new = LOC_LOG;
        end else if (loc == LOC_FROM_DB) begin
          loc_new = LOC_DB;
        end else if (loc == LOC_FROM_LOG) begin
          loc_new = LOC_LOG;
        end else begin
          loc_new = loc;
        end
        flags_new[FLAG_RES] = 1'b0;
      end
      default: begin
        loc_new = loc;
      end
    endcase
  end

  assign obj_we    = cmd.clr_step || (cmd.obj_op != OBJ_NONE);
  assign obj_waddr = cmd.clr_step ? clr_addr : obj_addr;
  assign obj_wdata = cmd.clr_step ? '0 : {loc_new, flags_new};

  lorm_ram #(.WIDTH(ID_W), .DEPTH(RESIDENT_SLOTS)) u_list_ram (
    .clk   (clk),
    .we    (list_we),
    .waddr (list_waddr),
    .wdata (list_wdata),
    .raddr (list_raddr),
    .rdata (list_rdata)
  );

  lorm_ram #(.WIDTH(ENTRY_W), .DEPTH(OBJECT_COUNT)) u_obj_ram (
    .clk   (clk),
    .we    (obj_we),
    .waddr (obj_waddr),
    .wdata (obj_wdata),
    .raddr (obj_addr),
    .rdata (obj_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= '0;
      clr_addr  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.scan_finish) begin
        if (scan_remove_r) begin
          total <= total - 1'b1;
        end else if (grow_r) begin
          total <= total + 1'b1;
        end
      end else if (cmd.evict_take) begin
        total <= total - 1'b1;
      end
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= req.op;
      cur_id <= req.object_id;
      n      <= '0;
    end else if (cmd.evict_take) begin
      cur_id <= list_rdata;
      n      <= n + 1'b1;
    end
    if (cmd.scan_start) begin
      idx           <= '0;
      carry         <= cur_id;
      found         <= 1'b0;
      scan_remove_r <= cmd.scan_remove;
      grow_r        <= cmd.scan_grow;
    end else if (cmd.scan_step) begin
      idx   <= idx + 1'b1;
      found <= found || (list_rdata == cur_id);
      if (!scan_remove_r) begin
        carry <= list_rdata;
      end
    end
    if (cmd.set_res) begin
      res_kind <= cmd.res_kind;
      res_last <= cmd.res_last;
      res_zero <= cmd.res_zero;
    end
    if (cmd.load_out) begin
      rsp.kind           <= res_kind;
      rsp.object_id_out  <= res_zero ? '0 : cur_id;
      rsp.resident_count <= total_ext[COUNT_W-1:0];
      rsp.last           <= res_last;
    end
  end

  always_comb begin
    st.clr_done    = clr_addr == OBJ_AW'(OBJECT_COUNT - 1);
    st.op          = op_r;
    st.id_bad      = (op_r > OP_GARBAGE) || (32'(cur_id) >= OBJECT_COUNT);
    st.res         = flags[FLAG_RES];
    st.garb        = flags[FLAG_GARB];
    st.full        = 32'(total) >= RESIDENT_SLOTS;
    st.over_cap    = 32'(total) > 32'(capacity);
    st.scan_end    = idx == total;
    st.match       = list_rdata == cur_id;
    st.scan_remove = scan_remove_r;
    st.n_limit     = n == MAX_OUT;
    st.res_last    = res_last;
    st.out_free    = !rsp_valid || !rsp_stall;
    if (loc == LOC_LOG) begin
      st.fetch_kind = KIND_FETCH_LOG;
    end else if (loc == LOC_DB) begin
      st.fetch_kind = KIND_FETCH_DB;
    end else begin
      st.fetch_kind = KIND_ACK;
    end
    if (flags[FLAG_GARB]) begin
      st.evict_kind = KIND_GARB_DROP;
    end else if (loc == LOC_DIRTY) begin
      st.evict_kind = KIND_WRITE_BACK;
    end else begin
      st.evict_kind = KIND_CLEAN_DROP;
    end
  end

endmodule

[design/lru_object_residency_manager.sv]
// ----------------------------------------------------------------------------
// lru_object_residency_manager
// Recency-ordered resident set of objects with per-object location tracking.
// ----------------------------------------------------------------------------
// After reset the block clears its object table and stalls requests
// meanwhile. Each word is handled on its own. An access that fetches or hits
// a resident object, and an unload of a resident object, walk the recency
// list entry by entry, with a read state and a write state per entry because
// the list memory has a registered read. A trim evicts objects one at a time,
// and every response word can be held while the result side stalls.
module lru_object_residency_manager #(
  parameter int RESIDENT_SLOTS = 64,
  parameter int OBJECT_COUNT   = 4096
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  lorm_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output lorm_pkg::rsp_t rsp,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import lorm_pkg::*;

  logic [CAP_W-1:0] capacity;
  cmd_t             cmd;
  status_t          st;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32 - CAP_W){1'b0}}, capacity} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  lorm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .st        (st),
    .cmd       (cmd)
  );

  lorm_dp #(
    .RESIDENT_SLOTS (RESIDENT_SLOTS),
    .OBJECT_COUNT   (OBJECT_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .capacity  (capacity),
    .st        (st),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
  );

endmodule

[sim/lru_object_residency_manager_tb.sv]
// ----------------------------------------------------------------------------
// lru_object_residency_manager_tb
// Self-checking testbench for the LRU object residency manager. A scoreboard
// keeps its own copy of the recency list and the object table, predicts every
// response word and compares it field by field. The run covers directed
// corner cases, random traffic on a small object pool across several
// capacities, random idling on both channels and one long response hold-off.
// ----------------------------------------------------------------------------
module lru_object_residency_manager_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lorm_pkg::*;

  class residency_scoreboard;
    rsp_t           rsp_q[$];
    logic [ID_W-1:0] lru[64];
    int             total;
    logic [LOC_W-1:0] loc[4096];
    logic [1:0]     flg[4096];
    int             cap;
    int             errors;

    function new();
      total = 0;
      cap = int'(CAP_RESET);
      errors = 0;
      foreach (loc[i]) begin
        loc[i] = LOC_DB;
        flg[i] = 2'b00;
      end
      foreach (lru[i]) lru[i] = '0;
    endfunction

    function void push(logic [KIND_W-1:0] k, logic [ID_W-1:0] id);
      rsp_t r;
      r.kind = k;
      r.object_id_out = id;
      r.resident_count = total[COUNT_W-1:0];
      r.last = 1'b0;
      rsp_q.push_back(r);
    endfunction

    function int find(logic [ID_W-1:0] id);
      for (int i = 0; i < total; i++) if (lru[i] == id) return i;
      return 64;
    endfunction

    function void drop_at(int p);
      for (int i = p; i + 1 < total; i++) lru[i] = lru[i + 1];
      total--;
    endfunction

    function void to_front(logic [ID_W-1:0] id);
      for (int i = total; i > 0; i--) lru[i] = lru[i - 1];
      lru[0] = id;
      total++;
    endfunction

    function void note(req_t r);
      int n;
      int p;
      logic [ID_W-1:0] v;
      logic [ID_W-1:0] id;
      logic [KIND_W-1:0] k;
      n = 0;
      id = r.object_id;
      if (r.op == OP_TRIM) begin
        while (total > cap && n < 64) begin
          v = lru[total - 1];
          total--;
          k = KIND_CLEAN_DROP;
          if (flg[v][FLAG_GARB]) begin
            loc[v] = LOC_DIRTY;
            k = KIND_GARB_DROP;
          end else if (loc[v] == LOC_DIRTY) begin
            loc[v] = LOC_LOG;
            k = KIND_WRITE_BACK;
          end else if (loc[v] == LOC_FROM_DB) begin
            loc[v] = LOC_DB;
          end else if (loc[v] == LOC_FROM_LOG) begin
            loc[v] = LOC_LOG;
          end
          flg[v][FLAG_RES] = 1'b0;
          push(k, v);
          n++;
        end
        if (n == 0) push(KIND_ACK, '0);
      end else if (r.op > OP_GARBAGE) begin
        push(KIND_IGNORED, id);
      end else if (r.op == OP_ACCESS) begin
        if (flg[id][FLAG_RES]) begin
          p = find(id);
          if (p < 64) begin
            drop_at(p);
            to_front(id);
            push(KIND_ACK, id);
          end else if (total < 64) begin
            to_front(id);
            push(KIND_ACK, id);
          end else begin
            push(KIND_OVERFLOW, id);
          end
        end else if (flg[id][FLAG_GARB]) begin
          push(KIND_IGNORED, id);
        end else if (total >= 64) begin
          push(KIND_OVERFLOW, id);
        end else begin
          k = KIND_ACK;
          if (loc[id] == LOC_LOG) begin
            loc[id] = LOC_FROM_LOG;
            k = KIND_FETCH_LOG;
          end else if (loc[id] == LOC_DB) begin
            loc[id] = LOC_FROM_DB;
            k = KIND_FETCH_DB;
          end
          to_front(id);
          flg[id][FLAG_RES] = 1'b1;
          push(k, id);
        end
      end else if (r.op == OP_UNLOAD) begin
        p = find(id);
        if (p < 64) drop_at(p);
        loc[id] = LOC_DIRTY;
        flg[id][FLAG_RES] = 1'b0;
        push(KIND_ACK, id);
      end else if (r.op == OP_MODIFY) begin
        if (flg[id][FLAG_RES]) begin
          loc[id] = LOC_DIRTY;
          push(KIND_ACK, id);
        end else begin
          push(KIND_IGNORED, id);
        end
      end else begin
        flg[id][FLAG_GARB] = 1'b1;
        push(KIND_ACK, id);
      end
      rsp_q[rsp_q.size() - 1].last = 1'b1;
    endfunction

    function void check(rsp_t got);
      rsp_t e;
      if (rsp_q.size() == 0) begin
        $error("unexpected response word kind=%0d id=%0d", got.kind, got.object_id_out);
        errors++;
        return;
      end
      e = rsp_q.pop_front();
      if (got.kind !== e.kind) begin
        $error("kind: expected %0d, got %0d", e.kind, got.kind);
        errors++;
      end
      if (got.object_id_out !== e.object_id_out) begin
        $error("object_id_out: expected %0d, got %0d", e.object_id_out, got.object_id_out);
        errors++;
      end
      if (got.resident_count !== e.resident_count) begin
        $error("resident_count: expected %0d, got %0d", e.resident_count,
               got.resident_count);
        errors++;
      end
      if (got.last !== e.last) begin
        $error("last: expected %0d, got %0d", e.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  req_t        req;
  logic        rsp_valid;
  logic        rsp_stall;
  rsp_t        rsp;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  residency_scoreboard sb;
  int tx_idle_pct;
  int rx_stall_pct;
  bit hold_req;

  lru_object_residency_manager dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  initial begin
    #30ms;
    $display("[lru_object_residency_manager] ERROR");
    $finish;
  end

  always @(negedge clk) begin : rsp_side
    int hold;
    if (hold_req) begin
      hold = 400;
      hold_req = 1'b0;
    end
    if (hold > 0) begin
      hold--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check(rsp);
  end

  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == {2'b00, REG_CAPACITY}) sb.cap = int'(data[CAP_W-1:0]);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_word(logic [OP_W-1:0] op, logic [ID_W-1:0] id);
    req_t r;
    r.op = op;
    r.object_id = id;
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall !== 1'b0);
    sb.note(r);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    while (sb.rsp_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_word(bit wide_ids);
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] id;
    int sel;
    sel = $urandom_range(99);
    if (sel < 50) op = OP_ACCESS;
    else if (sel < 62) op = OP_TRIM;
    else if (sel < 74) op = OP_UNLOAD;
    else if (sel < 86) op = OP_MODIFY;
    else if (sel < 93) op = OP_GARBAGE;
    else op = OP_W'($urandom_range(7));
    if (wide_ids || $urandom_range(9) == 0) id = ID_W'($urandom);
    else id = ID_W'($urandom_range(99));
    send_word(op, id);
  endtask

  initial begin : stim
    int caps[6];
    sb = new();
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_req = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_word(OP_TRIM, 12'd5);
    send_word(OP_ACCESS, 12'd0);
    send_word(OP_ACCESS, 12'hFFF);
    send_word(OP_ACCESS, 12'd0);
    send_word(OP_MODIFY, 12'd0);
    send_word(OP_MODIFY, 12'd5);
    send_word(OP_GARBAGE, 12'hFFF);
    send_word(OP_ACCESS, 12'hFFF);
    send_word(OP_ACCESS, 12'd7);
    send_word(OP_UNLOAD, 12'd0);
    send_word(OP_ACCESS, 12'd0);
    send_word(OP_GARBAGE, 12'd9);
    send_word(OP_ACCESS, 12'd9);
    send_word(3'd5, 12'd1);
    send_word(3'd7, 12'hFFF);
    send_word(OP_UNLOAD, 12'd33);
    wait_idle();
    cfg_write(3'd0, 32'd1);
    send_word(OP_TRIM, 12'hABC);
    send_word(OP_ACCESS, 12'd7);
    send_word(OP_ACCESS, 12'd3);
    send_word(OP_TRIM, 12'd0);
    wait_idle();

    caps = '{63, 0, 17, 1, 63, 32};
    for (int ph = 0; ph < 6; ph++) begin
      cfg_write(3'd0, caps[ph] | ($urandom & 32'hFFFF_FFC0));
      case (ph % 4)
        0: begin tx_idle_pct = 0; rx_stall_pct = 0; end
        1: begin tx_idle_pct = 63; rx_stall_pct = 0; end
        2: begin tx_idle_pct = 0; rx_stall_pct = 63; end
        default: begin tx_idle_pct = 37; rx_stall_pct = 37; end
      endcase
      if (ph == 4) begin
        tx_idle_pct = 0;
        hold_req = 1'b1;
        repeat (40) send_word(OP_ACCESS, ID_W'($urandom_range(99)));
        rx_stall_pct = 20;
      end
      for (int i = 0; i < 40; i++) random_word(ph == 2 && i < 10);
      wait_idle();
    end

    if (sb.errors == 0 && sb.rsp_q.size() == 0) begin
      $display("[lru_object_residency_manager] OK");
    end else begin
      $display("[lru_object_residency_manager] ERROR");
    end
    $finish;
  end
endmodule
